@@ design/eamt_pkg.sv @@
package eamt_pkg;

  localparam int unsigned NUM_MARKS = 26;
  localparam int unsigned POS_W     = 24;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned IDX_W     = 5;
  localparam int unsigned ST_W      = 3;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
  localparam logic [OP_W-1:0] OP_SET    = 3'd2;
  localparam logic [OP_W-1:0] OP_GET    = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_BOUNDS    = 3'd1;
  localparam logic [ST_W-1:0] ST_BAD_INDEX = 3'd2;
  localparam logic [ST_W-1:0] ST_NOT_SET   = 3'd3;
  localparam logic [ST_W-1:0] ST_OVERFLOW  = 3'd4;

  typedef enum logic [2:0] {
    KIND_NOP,
    KIND_INSERT,
    KIND_DELETE,
    KIND_SET,
    KIND_GET,
    KIND_CLEAR
  } kind_e;

  // Command token that walks the chain of mark cells. For a set, at holds the
  // already clamped mark position.
  typedef struct packed {
    kind_e             kind;
    logic [POS_W-1:0]  at;
    logic [POS_W-1:0]  len;
    logic [POS_W-1:0]  lim;
    logic [IDX_W-1:0]  idx;
    logic [ST_W-1:0]   status;
    logic [POS_W-1:0]  mpos;
    logic              present;
    logic [POS_W-1:0]  doclen;
  } tok_t;

endpackage

@@ design/eamt_cell.sv @@
module eamt_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic [eamt_pkg::IDX_W-1:0] cell_idx_i,
  input  logic                       vld_i,
  input  eamt_pkg::tok_t             tok_i,
  output logic                       vld_o,
  output eamt_pkg::tok_t             tok_o
);
  import eamt_pkg::*;

  logic [POS_W-1:0] pos_q, pos_d;
  logic             set_q, set_d;
  logic             vld_q;
  tok_t             tok_q, tok_d;
  logic             hit;

  assign hit = (tok_i.idx == cell_idx_i);

  always_comb begin
    tok_d = tok_i;
    pos_d = pos_q;
    set_d = set_q;
    if (vld_i) begin
      unique case (tok_i.kind)
        KIND_INSERT: begin
          if (set_q && pos_q >= tok_i.at) begin
            pos_d = pos_q + tok_i.len;
          end
        end
        KIND_DELETE: begin
          // Marks past the removed range slide down; marks inside collapse onto its start.
          if (set_q) begin
            if (pos_q >= tok_i.lim) begin
              pos_d = pos_q - tok_i.len;
            end else if (pos_q > tok_i.at) begin
              pos_d = tok_i.at;
            end
          end
        end
        KIND_SET: begin
          if (hit) begin
            pos_d = tok_i.at;
            set_d = 1'b1;
          end
        end
        KIND_GET: begin
          if (hit) begin
            if (set_q) begin
              tok_d.mpos    = pos_q;
              tok_d.present = 1'b1;
            end else begin
              tok_d.status  = ST_NOT_SET;
            end
          end
        end
        KIND_CLEAR: begin
          if (hit) begin
            set_d = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      set_q <= 1'b0;
      pos_q <= '0;
    end else if (adv_i) begin
      vld_q <= vld_i;
      set_q <= set_d;
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tok_q <= tok_d;
    end
  end

  assign vld_o = vld_q;
  assign tok_o = tok_q;

endmodule

@@ design/eamt_ctrl.sv @@
module eamt_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [eamt_pkg::OP_W-1:0]  operation_i,
  input  logic [eamt_pkg::POS_W-1:0] position_i,
  input  logic [eamt_pkg::POS_W-1:0] length_i,
  input  logic [eamt_pkg::IDX_W-1:0] mark_index_i,
  output eamt_pkg::tok_t             tok_o,
  output logic [eamt_pkg::POS_W-1:0] doc_len_o
);
  import eamt_pkg::*;

  logic [POS_W-1:0] doc_len_q, doc_len_d;
  logic             idx_bad;
  tok_t             tok;

  assign idx_bad = (mark_index_i >= IDX_W'(NUM_MARKS));

  always_comb begin
    doc_len_d   = doc_len_q;
    tok         = '0;
    tok.kind    = KIND_NOP;
    tok.at      = position_i;
    tok.len     = length_i;
    tok.lim     = position_i + length_i;
    tok.idx     = mark_index_i;
    tok.status  = ST_OK;
    unique case (operation_i)
      OP_INSERT: begin
        if (position_i > doc_len_q) begin
          tok.status = ST_BOUNDS;
        end else if (length_i > (POS_MAX - doc_len_q)) begin
          tok.status = ST_OVERFLOW;
        end else begin
          tok.kind  = KIND_INSERT;
          doc_len_d = doc_len_q + length_i;
        end
      end
      OP_DELETE: begin
        if (position_i > doc_len_q || length_i > (doc_len_q - position_i)) begin
          tok.status = ST_BOUNDS;
        end else begin
          tok.kind  = KIND_DELETE;
          doc_len_d = doc_len_q - length_i;
        end
      end
      OP_SET, OP_GET, OP_CLEAR: begin
        if (idx_bad) begin
          tok.status = ST_BAD_INDEX;
        end else if (operation_i == OP_SET) begin
          tok.kind = KIND_SET;
          tok.at   = (position_i > doc_len_q) ? doc_len_q : position_i;
        end else if (operation_i == OP_GET) begin
          tok.kind = KIND_GET;
        end else begin
          tok.kind = KIND_CLEAR;
        end
      end
      default: begin
      end
    endcase
    tok.doclen = doc_len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      doc_len_q <= '0;
    end else if (accept_i) begin
      doc_len_q <= doc_len_d;
    end
  end

  assign tok_o     = tok;
  assign doc_len_o = doc_len_q;

endmodule

@@ design/edit_anchor_mark_tracker.sv @@
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_ready_o  operation_i, position_i, length_i, mark_index_i
// out      output     out_valid_o / out_ready_i status_o, mark_position_o, mark_present_o,
//                                               document_length_o
//
// An accepted command is decoded and checked against the length in the accepting cycle,
// where it also passes the first of the 26 mark cells, one cell per cycle while the chain
// is not frozen; each cell registers it in turn before the result register is loaded.
// One command is in flight at a time: the next transfer is taken once the previous result
// has reached the output register. A stalled output freezes the chain when a finished
// command waits at its end; reset clears the length and all marks at once.
module edit_anchor_mark_tracker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [eamt_pkg::OP_W-1:0]  operation_i,
  input  logic [eamt_pkg::POS_W-1:0] position_i,
  input  logic [eamt_pkg::POS_W-1:0] length_i,
  input  logic [eamt_pkg::IDX_W-1:0] mark_index_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [eamt_pkg::ST_W-1:0]  status_o,
  output logic [eamt_pkg::POS_W-1:0] mark_position_o,
  output logic                       mark_present_o,
  output logic [eamt_pkg::POS_W-1:0] document_length_o
);
  import eamt_pkg::*;

  logic                 accept;
  logic                 adv;
  logic                 busy_q;
  logic                 out_valid_q;
  logic [NUM_MARKS:0]   vld;
  tok_t                 tok [NUM_MARKS+1];
  logic [POS_W-1:0]     doc_len;
  logic [ST_W-1:0]      status_q;
  logic [POS_W-1:0]     mpos_q;
  logic                 present_q;
  logic [POS_W-1:0]     doclen_q;

  assign in_ready_o = !busy_q;
  assign accept     = in_valid_i && !busy_q;

  // The chain only halts when a finished token cannot enter a full output register.
  assign adv = !(vld[NUM_MARKS] && out_valid_q && !out_ready_i);

  eamt_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .operation_i  (operation_i),
    .position_i   (position_i),
    .length_i     (length_i),
    .mark_index_i (mark_index_i),
    .tok_o        (tok[0]),
    .doc_len_o    (doc_len)
  );

  assign vld[0] = accept;

  for (genvar i = 0; i < NUM_MARKS; i++) begin : g_cell
    eamt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .adv_i      (adv),
      .cell_idx_i (IDX_W'(i)),
      .vld_i      (vld[i]),
      .tok_i      (tok[i]),
      .vld_o      (vld[i+1]),
      .tok_o      (tok[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (adv && vld[NUM_MARKS]) begin
        busy_q <= 1'b0;
      end
      if (adv && vld[NUM_MARKS]) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && vld[NUM_MARKS]) begin
      status_q  <= tok[NUM_MARKS].status;
      mpos_q    <= tok[NUM_MARKS].mpos;
      present_q <= tok[NUM_MARKS].present;
      doclen_q  <= tok[NUM_MARKS].doclen;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign mark_position_o   = mpos_q;
  assign mark_present_o    = present_q;
  assign document_length_o = doclen_q;

  a_one_token : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(vld))
    else $error("more than one command in the mark chain");

  a_idle_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (vld[NUM_MARKS:1] == '0))
    else $error("token in the chain while the block reports idle");

  a_len_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && vld[NUM_MARKS]) |=> (document_length_o == doc_len))
    else $error("reported length differs from the tracked length");

  a_present_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && mark_present_o) |-> (status_o == ST_OK))
    else $error("mark reported present with a failing status");

endmodule
